### hdl/tic_pkg.sv
// ----------------------------------------------------------------------------
// tic_pkg
// Types, codes and the opcode decoder shared by the issue control block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package tic_pkg;

  // Number of reservation stations, one busy bit each.
  localparam int unsigned NUM_STATIONS = 11;

  // Source station code for an instruction that takes no station.
  localparam logic [3:0] STATION_NONE = 4'hF;

  // Opcodes that are named in the decoder.
  localparam logic [7:0] OP_BRANCH = 8'h45;
  localparam logic [7:0] OP_SWI    = 8'h4C;
  localparam logic [7:0] OP_NOP    = 8'h4D;

  // Unit class; outside compares and NOPs, the code is also the allocation type reported on the output.
  typedef enum logic [2:0] {
    CLS_INTALU = 3'b000,
    CLS_INTMUL = 3'b001,
    CLS_FPALU  = 3'b010,
    CLS_FPMUL  = 3'b011,
    CLS_LOAD   = 3'b100,
    CLS_STORE  = 3'b101,
    CLS_BRANCH = 3'b110,
    CLS_NOP    = 3'b111
  } cls_t;

  // Allocation type of a compare that only writes flags.
  localparam logic [2:0] ATYPE_CMP  = 3'b111;
  localparam logic [2:0] ATYPE_NONE = 3'b000;

  // Floating-point unit codes.
  localparam logic [1:0] FPU_NONE = 2'd0;
  localparam logic [1:0] FPU_ALU  = 2'd1;
  localparam logic [1:0] FPU_MUL  = 2'd2;

  // One instruction presented for issue.
  typedef struct packed {
    logic                    inst_ready;
    logic [7:0]              opcode;
    logic                    rob_full;
    logic [NUM_STATIONS-1:0] busy_mask;
  } in_t;

  // Issue decision for one instruction.
  typedef struct packed {
    logic                    stall_fetch;
    logic                    rob_alloc;
    logic [NUM_STATIONS-1:0] grant_mask;
    logic [3:0]              source_station;
    logic [2:0]              alloc_type;
    logic                    tag_write_en;
    logic                    flags_tag_write_en;
    logic                    modifies_flags;
    logic                    needs_flags;
    logic                    use_imm;
    logic                    is_compare_only;
    logic [1:0]              fp_unit;
  } out_t;

  // Decoded attributes of one opcode.
  typedef struct packed {
    cls_t cls;
    logic mod;
    logic need;
    logic imm;
    logic cmp;
  } dec_t;

  // Opcode table. Unknown opcodes decode as NOP with every flag clear.
  function automatic dec_t decode_op(input logic [7:0] op);
    dec_t d;
    d = '{cls: CLS_NOP, mod: 1'b0, need: 1'b0, imm: 1'b0, cmp: 1'b0};
    case (op) inside
      [8'h00:8'h03], [8'h06:8'h0D]: begin
        d.cls = CLS_INTALU; d.mod = 1'b1;
      end
      [8'h0E:8'h11], [8'h14:8'h1D]: begin
        d.cls = CLS_INTALU; d.mod = 1'b1; d.imm = 1'b1;
      end
      8'h04, 8'h05: begin
        d.cls = CLS_INTMUL; d.mod = 1'b1;
      end
      8'h12, 8'h13: begin
        d.cls = CLS_INTMUL; d.mod = 1'b1; d.imm = 1'b1;
      end
      8'h1E, 8'h1F, 8'h22, [8'h29:8'h30]: begin
        d.cls = CLS_FPALU;
      end
      8'h23, 8'h24, 8'h27, [8'h53:8'h5A]: begin
        d.cls = CLS_FPALU; d.imm = 1'b1;
      end
      8'h20, 8'h21, 8'h28: begin
        d.cls = CLS_FPMUL;
      end
      8'h25, 8'h26, 8'h52: begin
        d.cls = CLS_FPMUL; d.imm = 1'b1;
      end
      8'h31, 8'h32: begin
        d.cls = CLS_INTALU;
      end
      [8'h33:8'h36]: begin
        d.cls = CLS_INTALU; d.imm = 1'b1;
      end
      [8'h37:8'h3A]: begin
        d.cls = CLS_INTALU; d.cmp = 1'b1; d.mod = 1'b1;
      end
      [8'h3B:8'h3E]: begin
        d.cls = CLS_INTALU; d.cmp = 1'b1; d.mod = 1'b1; d.imm = 1'b1;
      end
      [8'h3F:8'h41]: begin
        d.cls = CLS_FPALU; d.cmp = 1'b1; d.mod = 1'b1;
      end
      [8'h42:8'h44]: begin
        d.cls = CLS_FPALU; d.cmp = 1'b1; d.mod = 1'b1; d.imm = 1'b1;
      end
      OP_BRANCH: begin
        d.cls = CLS_BRANCH;
      end
      [8'h46:8'h4B]: begin
        d.cls = CLS_BRANCH; d.need = 1'b1;
      end
      8'h4E, 8'h50: begin
        d.cls = CLS_LOAD;
      end
      8'h4F, 8'h51: begin
        d.cls = CLS_STORE;
      end
      OP_SWI, OP_NOP: begin
        d.cls = CLS_NOP;
      end
      default: begin
        d.cls = CLS_NOP;
      end
    endcase
    // Carry arithmetic reads the flags.
    if (op == 8'h02 || op == 8'h03 || op == 8'h10 || op == 8'h11) begin
      d.need = 1'b1;
    end
    return d;
  endfunction

  // First station of a class.
  function automatic logic [3:0] cls_first(input cls_t cls);
    logic [3:0] f;
    case (cls)
      CLS_INTALU: f = 4'd5;
      CLS_INTMUL: f = 4'd8;
      CLS_FPALU:  f = 4'd7;
      CLS_FPMUL:  f = 4'd9;
      CLS_LOAD:   f = 4'd2;
      CLS_STORE:  f = 4'd0;
      CLS_BRANCH: f = 4'd10;
      default:    f = 4'd0;
    endcase
    return f;
  endfunction

  // Number of stations of a class.
  function automatic logic [1:0] cls_count(input cls_t cls);
    logic [1:0] c;
    case (cls)
      CLS_INTALU: c = 2'd2;
      CLS_LOAD:   c = 2'd3;
      CLS_STORE:  c = 2'd2;
      CLS_NOP:    c = 2'd0;
      default:    c = 2'd1;
    endcase
    return c;
  endfunction

endpackage

### hdl/tic_if.sv
// ----------------------------------------------------------------------------
// tic_in_if / tic_out_if
// Valid/ready channels that carry instructions into the issue control block
// and issue decisions out of it.
// ----------------------------------------------------------------------------
interface tic_in_if;
  import tic_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tic_out_if;
  import tic_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/tomasulo_issue_control.sv
// ----------------------------------------------------------------------------
// tomasulo_issue_control
// Issue stage of an out-of-order core: decodes an opcode, checks the reorder
// buffer and the reservation stations, and grants the first free station.
//
//   Channel  Direction  Carries
//   in_ch    sink       inst_ready, opcode, rob_full, busy_mask
//   out_ch   source     stall, ROB allocation, grant, decoded attributes
//
// One instruction per cycle while out_ch is not stalled: an input register, one
// level of decode and priority select, and a result register.
// rst_n is synchronous and clears the valid flags of both registers.
// Each register holds while the stage after it is stalled, so a stall on
// out_ch backs up to in_ch only once both registers are full.
// ----------------------------------------------------------------------------
module tomasulo_issue_control (
  input  logic      clk,
  input  logic      rst_n,
  tic_in_if.sink    in_ch,
  tic_out_if.source out_ch
);
  import tic_pkg::*;

  logic in_valid_r;
  in_t  in_data_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t res;
  logic out_take;
  logic in_take;

  // Each stage advances when it is empty or its contents move on.
  assign out_take    = !out_valid_r || out_ch.ready;
  assign in_take     = !in_valid_r || out_take;
  assign in_ch.ready = in_take;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_ch.valid) begin
      in_data_r <= in_ch.data;
    end
  end

  // Decode and station selection.
  always_comb begin
    dec_t       d;
    logic       found;
    logic [3:0] first;
    logic [1:0] count;
    logic [3:0] s;
    res   = '0;
    d     = decode_op(in_data_r.opcode);
    first = cls_first(d.cls);
    count = cls_count(d.cls);
    found = 1'b0;
    s     = '0;
    if (!in_data_r.inst_ready) begin
      res.stall_fetch = 1'b1;
    end else begin
      res.modifies_flags  = d.mod;
      res.needs_flags     = d.need;
      res.use_imm         = d.imm;
      res.is_compare_only = d.cmp;
      if (d.cls == CLS_FPALU) begin
        res.fp_unit = FPU_ALU;
      end else if (d.cls == CLS_FPMUL) begin
        res.fp_unit = FPU_MUL;
      end else begin
        res.fp_unit = FPU_NONE;
      end
      if (d.cmp) begin
        res.alloc_type = ATYPE_CMP;
      end else if (d.cls == CLS_NOP) begin
        res.alloc_type = ATYPE_NONE;
      end else begin
        res.alloc_type = d.cls;
      end

      if (in_data_r.rob_full) begin
        res.stall_fetch = 1'b1;
      end else if (d.cls == CLS_NOP) begin
        // NOP and SWI take only a reorder-buffer entry.
        res.rob_alloc      = 1'b1;
        res.source_station = STATION_NONE;
      end else begin
        // Lowest-numbered free station of the class wins.
        for (int k = 0; k < 3; k++) begin
          if (!found && (2'(k) < count) && !in_data_r.busy_mask[first + 4'(k)]) begin
            found = 1'b1;
            s     = first + 4'(k);
          end
        end
        if (found) begin
          res.rob_alloc          = 1'b1;
          res.grant_mask         = NUM_STATIONS'(1) << s;
          res.source_station     = s;
          res.tag_write_en       = !d.cmp && d.cls != CLS_STORE && d.cls != CLS_BRANCH;
          res.flags_tag_write_en = d.mod;
        end else begin
          res.stall_fetch = 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && in_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A station grant never lands on a busy station.
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && res.rob_alloc && res.source_station != STATION_NONE)
      |-> ((res.grant_mask & in_data_r.busy_mask) == '0))
    else $error("grant to a busy station");

  // A grant names exactly one station.
  a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.rob_alloc && out_data_r.source_station != STATION_NONE)
      |-> $onehot(out_data_r.grant_mask))
    else $error("grant is not one-hot");

  // A stalled instruction allocates nothing.
  a_stall_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.stall_fetch)
      |-> (!out_data_r.rob_alloc && out_data_r.grant_mask == '0
           && !out_data_r.tag_write_en && !out_data_r.flags_tag_write_en))
    else $error("stall with allocation");

  // The input side only blocks when both registers hold items.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r))
    else $error("input blocked with a free register");

endmodule
